@@ hdl/ple_pkg.sv @@
// ----------------------------------------------------------------------------
// ple_pkg
// Shared types and codes of the positional list engine: request and result
// payloads, operation codes and status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package ple_pkg;

  // Default number of list slots.
  localparam int CAPACITY_DEF = 32;

  // Operation codes carried in the func field of a request.
  localparam logic [2:0] FN_INS_HEAD = 3'd0;
  localparam logic [2:0] FN_INS_TAIL = 3'd1;
  localparam logic [2:0] FN_INS_AT   = 3'd2;
  localparam logic [2:0] FN_DEL_HEAD = 3'd3;
  localparam logic [2:0] FN_DEL_TAIL = 3'd4;
  localparam logic [2:0] FN_DEL_AT   = 3'd5;
  localparam logic [2:0] FN_READ     = 3'd6;

  // Status codes carried in the status field of a result.
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_BADPOS = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  typedef struct packed {
    logic [2:0]         func;
    logic signed [31:0] value;
    logic [7:0]         position;
  } ple_req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] value_res;
    logic               last;
  } ple_rsp_t;

endpackage

`default_nettype wire

@@ hdl/ple_ram.sv @@
// ----------------------------------------------------------------------------
// ple_ram
// Generic single-write, single-read synchronous RAM with a registered read.
// The read data holds its value in cycles without a read.
// ----------------------------------------------------------------------------
`default_nettype none

module ple_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ hdl/ple_occ_map.sv @@
// ----------------------------------------------------------------------------
// ple_occ_map
// Occupancy map of the slot store: one flag per slot, and the lowest free
// slot, which is where the next inserted value goes.
// ----------------------------------------------------------------------------
`default_nettype none

module ple_occ_map #(
  parameter int CAPACITY = 32
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        set_en,
  input  wire logic [$clog2(CAPACITY)-1:0] set_idx,
  input  wire logic                        clr_en,
  input  wire logic [$clog2(CAPACITY)-1:0] clr_idx,
  output logic      [$clog2(CAPACITY)-1:0] free_idx,
  output logic      [CAPACITY-1:0]         occ
);

  localparam int SW = $clog2(CAPACITY);

  logic [CAPACITY-1:0] occ_r;
  logic [CAPACITY-1:0] occ_nxt;

  always_comb begin
    occ_nxt = occ_r;
    if (clr_en) begin
      occ_nxt[clr_idx] = 1'b0;
    end
    if (set_en) begin
      occ_nxt[set_idx] = 1'b1;
    end
  end

  // Lowest free slot; when the store is full the answer is not used.
  always_comb begin
    free_idx = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (!occ_r[i]) begin
        free_idx = SW'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  assign occ = occ_r;

endmodule

`default_nettype wire

@@ hdl/ple_ctrl.sv @@
// ----------------------------------------------------------------------------
// ple_ctrl
// Sequencer of the list engine: decodes a request, walks the links in the
// link RAM one per cycle, commits the pointer updates and drives the result
// register.
// ----------------------------------------------------------------------------
`default_nettype none

module ple_ctrl
  import ple_pkg::*;
#(
  parameter int CAPACITY = 32
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // Request channel.
  input  wire logic                        in_valid,
  input  wire ple_req_t                    in_data,
  output logic                             in_stall,
  // Result channel.
  output logic                             out_valid,
  output ple_rsp_t                         out_data,
  input  wire logic                        out_stall,
  // Occupancy map.
  input  wire logic [$clog2(CAPACITY)-1:0] free_idx,
  output logic                             occ_set,
  output logic [$clog2(CAPACITY)-1:0]      occ_set_idx,
  output logic                             occ_clr,
  output logic [$clog2(CAPACITY)-1:0]      occ_clr_idx,
  // Shared read port of both RAMs.
  output logic                             rd_en,
  output logic [$clog2(CAPACITY)-1:0]      rd_addr,
  input  wire logic [31:0]                 val_rdata,
  input  wire logic [$clog2(CAPACITY)-1:0] lnk_rdata,
  // Write ports.
  output logic                             val_we,
  output logic [$clog2(CAPACITY)-1:0]      val_waddr,
  output logic [31:0]                      val_wdata,
  output logic                             lnk_we,
  output logic [$clog2(CAPACITY)-1:0]      lnk_waddr,
  output logic [$clog2(CAPACITY)-1:0]      lnk_wdata
);

  localparam int SW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [9:0] {
    S_IDLE      = 10'b00_0000_0001,
    S_DECODE    = 10'b00_0000_0010,
    S_WALK      = 10'b00_0000_0100,
    S_INS_W1    = 10'b00_0000_1000,
    S_INS_W2    = 10'b00_0001_0000,
    S_DROP_HEAD = 10'b00_0010_0000,
    S_DA_CUR    = 10'b00_0100_0000,
    S_DA_COMMIT = 10'b00_1000_0000,
    S_READ      = 10'b01_0000_0000,
    S_RESP      = 10'b10_0000_0000
  } state_t;

  // What to do once the walk has reached its node.
  typedef enum logic [1:0] {
    WOP_INS_AT,
    WOP_DROP_HEAD,
    WOP_DROP_TAIL,
    WOP_DROP_AT
  } walk_op_t;

  state_t             state_r, state_nxt;
  logic [2:0]         func_r, func_nxt;
  logic [31:0]        value_r, value_nxt;
  logic [7:0]         pos_r, pos_nxt;
  logic [SW-1:0]      head_r, head_nxt;
  logic [SW-1:0]      tail_r, tail_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [SW-1:0]      cur_r, cur_nxt;
  logic [SW-1:0]      prev_r, prev_nxt;
  logic [CW-1:0]      rem_r, rem_nxt;
  logic               pend_r, pend_nxt;
  walk_op_t           wop_r, wop_nxt;
  status_t            status_r, status_nxt;
  logic               out_valid_r, out_valid_nxt;
  ple_rsp_t           out_r, out_nxt;

  logic               full;
  logic               out_free;
  logic [SW-1:0]      node;
  logic [7:0]         count8;
  logic [7:0]         pos_m1;
  logic [7:0]         ins_k;
  logic [CW-1:0]      ins_steps;
  logic [CW-1:0]      drop_at_steps;
  logic [CW-1:0]      tail_steps;

  assign full     = (count_r == CW'(CAPACITY));
  assign out_free = !out_valid_r || !out_stall;
  // While a link read is in flight, the walk pointer is the RAM output.
  assign node     = pend_r ? lnk_rdata : cur_r;

  assign count8        = 8'(count_r);
  assign pos_m1        = pos_r - 8'd1;
  assign ins_k         = (pos_m1 > count8) ? count8 : pos_m1;
  assign ins_steps     = CW'(ins_k - 8'd1);
  assign drop_at_steps = CW'(pos_r - 8'd2);
  assign tail_steps    = count_r - CW'(2);

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    func_nxt      = func_r;
    value_nxt     = value_r;
    pos_nxt       = pos_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    count_nxt     = count_r;
    cur_nxt       = cur_r;
    prev_nxt      = prev_r;
    rem_nxt       = rem_r;
    pend_nxt      = pend_r;
    wop_nxt       = wop_r;
    status_nxt    = status_r;
    out_nxt       = out_r;
    out_valid_nxt = out_stall ? out_valid_r : 1'b0;

    occ_set     = 1'b0;
    occ_set_idx = free_idx;
    occ_clr     = 1'b0;
    occ_clr_idx = prev_r;
    rd_en       = 1'b0;
    rd_addr     = node;
    val_we      = 1'b0;
    val_waddr   = free_idx;
    val_wdata   = value_r;
    lnk_we      = 1'b0;
    lnk_waddr   = free_idx;
    lnk_wdata   = head_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          func_nxt  = in_data.func;
          value_nxt = in_data.value;
          pos_nxt   = in_data.position;
          state_nxt = S_DECODE;
        end
      end

      S_DECODE: begin
        status_nxt = ST_OK;
        state_nxt  = S_RESP;
        cur_nxt    = head_r;
        pend_nxt   = 1'b0;
        unique case (func_r)
          FN_INS_HEAD, FN_INS_AT: begin
            if (full) begin
              status_nxt = ST_FULL;
            end else if (func_r == FN_INS_HEAD || pos_r == 8'd1) begin
              // New slot becomes the head and links to the old head.
              val_we   = 1'b1;
              lnk_we   = 1'b1;
              occ_set  = 1'b1;
              head_nxt = free_idx;
              if (count_r == '0) begin
                tail_nxt = free_idx;
              end
              count_nxt = count_r + CW'(1);
            end else if (pos_r == 8'd0 || count_r == '0) begin
              status_nxt = ST_BADPOS;
            end else begin
              wop_nxt   = WOP_INS_AT;
              rem_nxt   = ins_steps;
              state_nxt = S_WALK;
            end
          end
          FN_INS_TAIL: begin
            if (full) begin
              status_nxt = ST_FULL;
            end else begin
              val_we  = 1'b1;
              occ_set = 1'b1;
              if (count_r == '0) begin
                head_nxt = free_idx;
              end else begin
                lnk_we    = 1'b1;
                lnk_waddr = tail_r;
                lnk_wdata = free_idx;
              end
              tail_nxt  = free_idx;
              count_nxt = count_r + CW'(1);
            end
          end
          FN_DEL_HEAD: begin
            if (count_r == '0) begin
              status_nxt = ST_EMPTY;
            end else begin
              wop_nxt   = WOP_DROP_HEAD;
              rem_nxt   = '0;
              state_nxt = S_WALK;
            end
          end
          FN_DEL_TAIL: begin
            if (count_r == '0) begin
              status_nxt = ST_EMPTY;
            end else if (count_r == CW'(1)) begin
              wop_nxt   = WOP_DROP_HEAD;
              rem_nxt   = '0;
              state_nxt = S_WALK;
            end else begin
              wop_nxt   = WOP_DROP_TAIL;
              rem_nxt   = tail_steps;
              state_nxt = S_WALK;
            end
          end
          FN_DEL_AT: begin
            if (count_r == '0) begin
              status_nxt = ST_EMPTY;
            end else if (pos_r <= 8'd1) begin
              wop_nxt   = WOP_DROP_HEAD;
              rem_nxt   = '0;
              state_nxt = S_WALK;
            end else if (pos_r > count8) begin
              status_nxt = ST_BADPOS;
            end else begin
              wop_nxt   = WOP_DROP_AT;
              rem_nxt   = drop_at_steps;
              state_nxt = S_WALK;
            end
          end
          FN_READ: begin
            if (count_r == '0) begin
              status_nxt = ST_EMPTY;
            end else begin
              rd_en     = 1'b1;
              rd_addr   = head_r;
              rem_nxt   = count_r;
              state_nxt = S_READ;
            end
          end
          default: begin
            // Unused code: acknowledged with status ok, nothing changes.
            status_nxt = ST_OK;
          end
        endcase
      end

      S_WALK: begin
        if (rem_r != '0) begin
          rd_en    = 1'b1;
          cur_nxt  = node;
          pend_nxt = 1'b1;
          rem_nxt  = rem_r - CW'(1);
        end else begin
          prev_nxt = node;
          unique case (wop_r)
            WOP_INS_AT: begin
              rd_en     = 1'b1;
              state_nxt = S_INS_W1;
            end
            WOP_DROP_HEAD: begin
              rd_en     = 1'b1;
              state_nxt = S_DROP_HEAD;
            end
            WOP_DROP_AT: begin
              rd_en     = 1'b1;
              state_nxt = S_DA_CUR;
            end
            WOP_DROP_TAIL: begin
              occ_clr     = 1'b1;
              occ_clr_idx = tail_r;
              tail_nxt    = node;
              count_nxt   = count_r - CW'(1);
              state_nxt   = S_RESP;
            end
            default: begin
              state_nxt = S_RESP;
            end
          endcase
        end
      end

      S_INS_W1: begin
        // New slot takes the value and inherits the successor of prev.
        val_we    = 1'b1;
        lnk_we    = 1'b1;
        lnk_wdata = lnk_rdata;
        state_nxt = S_INS_W2;
      end

      S_INS_W2: begin
        lnk_we    = 1'b1;
        lnk_waddr = prev_r;
        lnk_wdata = free_idx;
        occ_set   = 1'b1;
        if (prev_r == tail_r) begin
          tail_nxt = free_idx;
        end
        count_nxt = count_r + CW'(1);
        state_nxt = S_RESP;
      end

      S_DROP_HEAD: begin
        occ_clr   = 1'b1;
        head_nxt  = lnk_rdata;
        count_nxt = count_r - CW'(1);
        if (count_r == CW'(1)) begin
          head_nxt = '0;
          tail_nxt = '0;
        end
        state_nxt = S_RESP;
      end

      S_DA_CUR: begin
        cur_nxt   = lnk_rdata;
        rd_en     = 1'b1;
        rd_addr   = lnk_rdata;
        state_nxt = S_DA_COMMIT;
      end

      S_DA_COMMIT: begin
        lnk_we      = 1'b1;
        lnk_waddr   = prev_r;
        lnk_wdata   = lnk_rdata;
        occ_clr     = 1'b1;
        occ_clr_idx = cur_r;
        if (cur_r == tail_r) begin
          tail_nxt = prev_r;
        end
        count_nxt = count_r - CW'(1);
        state_nxt = S_RESP;
      end

      S_READ: begin
        // The RAM output holds while the result register is blocked.
        if (out_free) begin
          out_valid_nxt     = 1'b1;
          out_nxt.status    = ST_OK;
          out_nxt.value_res = val_rdata;
          out_nxt.last      = (rem_r == CW'(1));
          rem_nxt           = rem_r - CW'(1);
          if (rem_r == CW'(1)) begin
            state_nxt = S_IDLE;
          end else begin
            rd_en   = 1'b1;
            rd_addr = lnk_rdata;
          end
        end
      end

      S_RESP: begin
        if (out_free) begin
          out_valid_nxt     = 1'b1;
          out_nxt.status    = status_r;
          out_nxt.value_res = '0;
          out_nxt.last      = 1'b1;
          state_nxt         = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      rem_r       <= '0;
      pend_r      <= 1'b0;
      wop_r       <= WOP_INS_AT;
      status_r    <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      rem_r       <= rem_nxt;
      pend_r      <= pend_nxt;
      wop_r       <= wop_nxt;
      status_r    <= status_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r  <= func_nxt;
    value_r <= value_nxt;
    pos_r   <= pos_nxt;
    cur_r   <= cur_nxt;
    prev_r  <= prev_nxt;
    out_r   <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

@@ hdl/positional_list_engine_unit.sv @@
// ----------------------------------------------------------------------------
// positional_list_engine_unit
// Ordered list of signed 32-bit values kept as a singly linked list in a
// value RAM and a link RAM, with an occupancy map that hands out the lowest
// free slot. Supports head, tail and positional insert and delete, and a
// read-out of the whole list.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Payload     Handshake
//  --------  ---------  ----------  ------------------------------------------
//  in_*      input      ple_req_t   taken when in_valid is high, in_stall low
//  out_*     output     ple_rsp_t   taken when out_valid is high, out_stall low
//
// Head insert, tail insert and the error answers go from the decode state
// straight to the result state. Positional inserts and deletes and tail
// deletes walk the link RAM one link per cycle before they commit, while a
// head delete reads only the head's link. A read gives one result per cycle
// while the result register is not stalled.
// The link RAM read port sets this pace: each step of a walk is one read.
// Reset clears the occupancy map, the head, tail and count registers and the
// sequencer; the RAMs are not cleared, as the occupancy map guards them.
// A stalled result register holds the sequencer in its read-out or result
// state; requests are taken one at a time, and the next one may be taken
// while a result still waits on the output.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_list_engine_unit
  import ple_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  input  wire ple_req_t in_data,
  output logic          in_stall,
  output logic          out_valid,
  output ple_rsp_t      out_data,
  input  wire logic     out_stall
);

  localparam int SW = $clog2(CAPACITY);

  // Occupancy map interface.
  logic [SW-1:0]       free_idx;
  logic                occ_set;
  logic [SW-1:0]       occ_set_idx;
  logic                occ_clr;
  logic [SW-1:0]       occ_clr_idx;
  logic [CAPACITY-1:0] occ;

  // Both RAMs share one read address, so a read-out step fetches the value
  // and the link of the same element in the same cycle.
  logic                rd_en;
  logic [SW-1:0]       rd_addr;
  logic [31:0]         val_rdata;
  logic [SW-1:0]       lnk_rdata;
  logic                val_we;
  logic [SW-1:0]       val_waddr;
  logic [31:0]         val_wdata;
  logic                lnk_we;
  logic [SW-1:0]       lnk_waddr;
  logic [SW-1:0]       lnk_wdata;

  ple_ctrl #(
    .CAPACITY(CAPACITY)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_data    (in_data),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_data   (out_data),
    .out_stall  (out_stall),
    .free_idx   (free_idx),
    .occ_set    (occ_set),
    .occ_set_idx(occ_set_idx),
    .occ_clr    (occ_clr),
    .occ_clr_idx(occ_clr_idx),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .val_rdata  (val_rdata),
    .lnk_rdata  (lnk_rdata),
    .val_we     (val_we),
    .val_waddr  (val_waddr),
    .val_wdata  (val_wdata),
    .lnk_we     (lnk_we),
    .lnk_waddr  (lnk_waddr),
    .lnk_wdata  (lnk_wdata)
  );

  ple_occ_map #(
    .CAPACITY(CAPACITY)
  ) u_occ_map (
    .clk     (clk),
    .rst_n   (rst_n),
    .set_en  (occ_set),
    .set_idx (occ_set_idx),
    .clr_en  (occ_clr),
    .clr_idx (occ_clr_idx),
    .free_idx(free_idx),
    .occ     (occ)
  );

  // Value store: one signed 32-bit value per slot.
  ple_ram #(
    .WIDTH(32),
    .DEPTH(CAPACITY)
  ) u_val_ram (
    .clk  (clk),
    .we   (val_we),
    .waddr(val_waddr),
    .wdata(val_wdata),
    .re   (rd_en),
    .raddr(rd_addr),
    .rdata(val_rdata)
  );

  // Link store: slot index of the next element for each slot.
  ple_ram #(
    .WIDTH(SW),
    .DEPTH(CAPACITY)
  ) u_lnk_ram (
    .clk  (clk),
    .we   (lnk_we),
    .waddr(lnk_waddr),
    .wdata(lnk_wdata),
    .re   (rd_en),
    .raddr(rd_addr),
    .rdata(lnk_rdata)
  );

  // An accepted request keeps the input closed for at least its decode cycle.
  a_stall_after_accept : assert property (
    @(posedge clk) disable iff (!rst_n)
      (in_valid && !in_stall) |=> in_stall
  ) else $error("request accepted while the previous one is still decoding");

  // A new value only ever lands in a slot the occupancy map shows as free.
  a_write_free_slot : assert property (
    @(posedge clk) disable iff (!rst_n)
      val_we |-> !occ[val_waddr]
  ) else $error("value written into an occupied slot");

  // The sequencer never reads a link in the cycle it rewrites that link.
  a_no_link_overlap : assert property (
    @(posedge clk) disable iff (!rst_n)
      (lnk_we && rd_en) |-> (lnk_waddr != rd_addr)
  ) else $error("link read and write to the same slot in one cycle");

  // A slot is never taken and released in the same cycle.
  a_set_clr_exclusive : assert property (
    @(posedge clk) disable iff (!rst_n)
      !(occ_set && occ_clr)
  ) else $error("occupancy set and clear in the same cycle");

endmodule

`default_nettype wire

@@ test/positional_list_engine_unit_test.sv @@
// ----------------------------------------------------------------------------
// positional_list_engine_unit_test
// Self-checking bench for the positional list engine. Requests are driven on
// the in_ channel and every result on the out_ channel is checked against a
// queue-based model of the list. The run starts with directed edge cases and
// continues with a random mix of inserts, deletes and reads. Random idle
// gaps are applied on the request side and stall bursts on the result side.
// ----------------------------------------------------------------------------
module positional_list_engine_unit_test
  import ple_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // Number of slots in the store. The unit is built with its default size.
  localparam int LIST_CAPACITY = CAPACITY_DEF;
  // The unit ignores this function code and answers with a plain OK.
  localparam logic [2:0] FN_NONE = 3'd7;
  // The longest walk covers fewer than CAPACITY links. The bench waits
  // longer than that walk and its setup before it trusts the unit to be idle.
  localparam int SETTLE_CYCLES = LIST_CAPACITY + 12;
  // Cycles with no request and no result accepted before the run is given up.
  // The slowest correct gap is an idle burst, a full-length walk and a stall
  // burst together, well under this limit.
  localparam int WATCHDOG_LIMIT = 2000;

  localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  ple_req_t in_data = '0;
  logic     in_stall;
  logic     out_valid;
  ple_rsp_t out_data;
  logic     out_stall = 1'b0;

  // The bench's own picture of the list, head at index 0. Slot allocation
  // inside the unit is not visible at the ports, so order and count are
  // all that the model has to keep.
  logic signed [31:0] list_model[$];
  // Results still owed by the unit, oldest first.
  ple_rsp_t expected_rsp[$];
  ple_rsp_t expected_head;

  int  errors = 0;
  int  idle_cycles = 0;
  int  stall_left = 0;
  // When set, neither side inserts idle cycles.
  bit  quiet = 1'b0;

  positional_list_engine_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // List model
  // --------------------------------------------------------------------------

  function automatic void push_answer(logic [1:0] st, logic signed [31:0] v, logic lst);
    ple_rsp_t r;
    r.status    = st;
    r.value_res = v;
    r.last      = lst;
    expected_rsp.push_back(r);
  endfunction

  // Applies one accepted request to the list model and queues the results
  // that it must produce.
  function automatic void apply_list_op(ple_req_t req);
    int         n;
    int         k;
    logic [1:0] st;
    n  = list_model.size();
    st = ST_OK;
    case (req.func)
      FN_INS_HEAD: begin
        if (n >= LIST_CAPACITY) st = ST_FULL;
        else list_model.push_front(req.value);
      end
      FN_INS_TAIL: begin
        if (n >= LIST_CAPACITY) st = ST_FULL;
        else list_model.push_back(req.value);
      end
      FN_INS_AT: begin
        // A full store wins over any position check, and position 1 is a
        // head insert even into an empty list.
        if (n >= LIST_CAPACITY) begin
          st = ST_FULL;
        end else if (req.position == 8'd1) begin
          list_model.push_front(req.value);
        end else if (req.position == 8'd0 || n == 0) begin
          st = ST_BADPOS;
        end else begin
          // Goes in after element position-1; past the end it appends.
          k = int'(req.position) - 1;
          if (k > n) k = n;
          list_model.insert(k, req.value);
        end
      end
      FN_DEL_HEAD: begin
        if (n == 0) st = ST_EMPTY;
        else void'(list_model.pop_front());
      end
      FN_DEL_TAIL: begin
        if (n == 0) st = ST_EMPTY;
        else void'(list_model.pop_back());
      end
      FN_DEL_AT: begin
        // Positions 0 and 1 both remove the head.
        if (n == 0) st = ST_EMPTY;
        else if (req.position <= 8'd1) void'(list_model.pop_front());
        else if (int'(req.position) > n) st = ST_BADPOS;
        else list_model.delete(int'(req.position) - 1);
      end
      FN_READ: begin
        if (n == 0) begin
          st = ST_EMPTY;
        end else begin
          for (int i = 0; i < n; i++) begin
            push_answer(ST_OK, list_model[i], (i == n - 1));
          end
          return;
        end
      end
      default: begin
      end
    endcase
    push_answer(st, '0, 1'b1);
  endfunction

  // --------------------------------------------------------------------------
  // Request driver
  // --------------------------------------------------------------------------

  // Sends one request and returns at the clock edge where it was taken. The
  // stall is looked at on the falling edge, where it is settled, so the
  // decision never races the unit's own update at the rising edge. The model
  // is advanced at that point, which is always before the first result of
  // the request can appear.
  task automatic send_request(input logic [2:0] fn, input logic signed [31:0] val,
                              input logic [7:0] pos);
    ple_req_t req;
    logic     taken;
    req.func     = fn;
    req.value    = val;
    req.position = pos;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !in_stall;
      if (taken) apply_list_op(req);
      @(posedge clk);
    end
  endtask

  // Holds off new requests until every owed result has come back, then lets
  // a full walk's worth of cycles pass so the unit is truly idle.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (expected_rsp.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Data values lean on the extremes now and then; otherwise all 32 bits are
  // random, so every bit of the field is exercised both ways.
  function automatic logic signed [31:0] random_value();
    case ($urandom_range(0, 15))
      0:       return VAL_MAX;
      1:       return VAL_MIN;
      2:       return '0;
      3:       return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  // Most positions fall inside the list or just past its end, so that the
  // walk does real work. The rest hit 0 and 1 or anywhere in the field.
  function automatic logic [7:0] random_position(int n);
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 8'($urandom_range(1, n + 1));
    else if (pick < 75) return 8'($urandom_range(0, 1));
    else return 8'($urandom_range(0, 255));
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Every delete and read on an empty list, the insert position errors on an
  // empty list, the ignored code, and a head insert through position 1.
  task automatic test_empty_list_errors();
    send_request(FN_READ,     '0, 8'd0);
    send_request(FN_DEL_HEAD, '0, 8'd0);
    send_request(FN_DEL_TAIL, '0, 8'd0);
    send_request(FN_DEL_AT,   '0, 8'd3);
    send_request(FN_INS_AT,   32'sd17, 8'd2);
    send_request(FN_INS_AT,   32'sd18, 8'd0);
    send_request(FN_NONE,     VAL_MIN, 8'd255);
    send_request(FN_INS_AT,   VAL_MAX, 8'd1);
  endtask

  // Inserts at each end and in the middle, append past the end, the
  // out-of-range positions, deletes of head and middle by position, tail
  // deletes, and the list emptied again.
  task automatic test_edits_and_bounds();
    send_request(FN_INS_TAIL, VAL_MIN, 8'd0);
    send_request(FN_INS_HEAD, -32'sd1, 8'd0);
    send_request(FN_INS_AT,   '0, 8'd255);
    send_request(FN_INS_AT,   32'sd5, 8'd2);
    send_request(FN_INS_AT,   32'sd6, 8'd0);
    send_request(FN_READ,     '0, 8'd0);
    send_request(FN_DEL_AT,   '0, 8'd255);
    send_request(FN_DEL_AT,   '0, 8'd0);
    send_request(FN_DEL_AT,   '0, 8'd2);
    send_request(FN_DEL_AT,   '0, 8'd3);
    send_request(FN_DEL_TAIL, '0, 8'd0);
    send_request(FN_NONE,     -32'sd1, 8'd255);
    send_request(FN_DEL_TAIL, '0, 8'd0);
    send_request(FN_DEL_AT,   '0, 8'd1);
    send_request(FN_READ,     '0, 8'd0);
  endtask

  // Fills the store with a mix of inserts, then checks that every kind of
  // insert is refused ahead of any position check and reads all 32 back.
  task automatic test_store_full();
    int pick;
    while (list_model.size() < LIST_CAPACITY) begin
      pick = $urandom_range(0, 2);
      if (pick == 0) send_request(FN_INS_HEAD, random_value(), 8'd0);
      else if (pick == 1) send_request(FN_INS_TAIL, random_value(), 8'd0);
      else send_request(FN_INS_AT, random_value(), random_position(list_model.size()));
    end
    send_request(FN_INS_HEAD, 32'sd1, 8'd0);
    send_request(FN_INS_TAIL, 32'sd2, 8'd0);
    send_request(FN_INS_AT,   32'sd3, 8'd0);
    send_request(FN_INS_AT,   32'sd4, 8'd1);
    send_request(FN_READ,     '0, 8'd0);
    send_request(FN_DEL_AT,   '0, 8'(LIST_CAPACITY));
    send_request(FN_INS_AT,   32'sd7, 8'd255);
    send_request(FN_READ,     '0, 8'd0);
  endtask

  // Random walk over the list size. The mix drifts between growing and
  // shrinking so that the list spends time both near empty and near full.
  task automatic test_random_mix(input int count);
    int         n;
    int         pick;
    bit         grow;
    logic [2:0] fn;
    grow = 1'b1;
    for (int i = 0; i < count; i++) begin
      n = list_model.size();
      if (n == 0) grow = 1'b1;
      else if (n >= LIST_CAPACITY - 1) grow = 1'b0;
      else if ($urandom_range(0, 19) == 0) grow = !grow;
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        fn = FN_READ;
      end else if (pick < 13) begin
        fn = FN_NONE;
      end else if ($urandom_range(0, 99) < (grow ? 75 : 25)) begin
        pick = $urandom_range(0, 2);
        fn = (pick == 0) ? FN_INS_HEAD : (pick == 1) ? FN_INS_TAIL : FN_INS_AT;
      end else begin
        pick = $urandom_range(0, 2);
        fn = (pick == 0) ? FN_DEL_HEAD : (pick == 1) ? FN_DEL_TAIL : FN_DEL_AT;
      end
      // Some stretches run without any idling on either side.
      if (i % 40 == 0) quiet = ($urandom_range(0, 3) == 0);
      send_request(fn, random_value(), random_position(n));
    end
  endtask

  task automatic test_random_mix_quiet(input int count);
    int         n;
    logic [2:0] fn;
    for (int i = 0; i < count; i++) begin
      n  = list_model.size();
      fn = 3'($urandom_range(0, 7));
      send_request(fn, random_value(), random_position(n));
    end
  endtask

  // Back-to-back traffic with no idling at all, to close the run.
  task automatic test_back_to_back(input int count);
    quiet = 1'b1;
    test_random_mix_quiet(count);
  endtask

  // --------------------------------------------------------------------------
  // Result side
  // --------------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    errors++;
  endtask

  // Random stall bursts on the result channel.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 14);
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // A result is checked on the falling edge before the rising edge that
  // takes it; valid and stall are both settled there.
  always @(negedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_rsp.size() == 0) begin
        report_mismatch($sformatf("result with nothing owed: status %0d value %0d last %0d",
                                  out_data.status, out_data.value_res, out_data.last));
      end else begin
        expected_head = expected_rsp.pop_front();
        if (out_data.status !== expected_head.status)
          report_mismatch($sformatf("status %0d, expected %0d",
                                    out_data.status, expected_head.status));
        if (out_data.value_res !== expected_head.value_res)
          report_mismatch($sformatf("value_res %0d, expected %0d",
                                    out_data.value_res, expected_head.value_res));
        if (out_data.last !== expected_head.last)
          report_mismatch($sformatf("last %0d, expected %0d",
                                    out_data.last, expected_head.last));
      end
    end
  end

  // Gives up when neither channel has moved for too long.
  always @(negedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no request or result accepted for %0d cycles", idle_cycles);
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_list_errors();
    test_edits_and_bounds();
    // The sender stops here until the unit has answered everything.
    wait_for_results();
    test_store_full();
    test_random_mix(215);
    test_back_to_back(30);

    wait_for_results();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
